@@ design/csdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csdc_pkg;

	localparam int unsigned XTAL_W  = 27;
	localparam int unsigned HZ_W    = 32;
	localparam int unsigned FREQ_W  = 28;
	localparam int unsigned DIVN_W  = 11;
	localparam int unsigned CODE_W  = 3;
	localparam int unsigned FPLL_W  = FREQ_W + DIVN_W;
	localparam int unsigned MULT_W  = 18;
	localparam int unsigned NUM_W   = 20;

	// serial divider sizing
	localparam int unsigned DVD_W   = 49;
	localparam int unsigned DSR_W   = 28;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned SHORT_W = 30;

	localparam logic [XTAL_W-1:0] XTAL_RESET = XTAL_W'(25000000);
	localparam logic [HZ_W-1:0]   HZ_MIN     = HZ_W'(8000);
	localparam logic [HZ_W-1:0]   HZ_MAX     = HZ_W'(150000000);
	localparam logic [FREQ_W-1:0] F_LOW      = FREQ_W'(500000);
	localparam logic [CODE_W-1:0] CODE_MAX   = CODE_W'(7);
	localparam logic [SHORT_W-1:0] VCO_NOM   = SHORT_W'(800000000);
	localparam logic [SHORT_W-1:0] VCO_MIN   = SHORT_W'(600000000);
	localparam logic [FPLL_W-1:0] VCO_MIN_W  = FPLL_W'(600000000);
	localparam logic [FPLL_W-1:0] VCO_MAX_W  = FPLL_W'(900000000);
	localparam logic [DIVN_W-1:0] MS_MIN     = DIVN_W'(8);
	localparam logic [DIVN_W-1:0] MS_MAX     = DIVN_W'(900);
	localparam logic [MULT_W-1:0] MULT_MAX   = MULT_W'(262143);
	localparam logic [NUM_W-1:0]  DENOM      = NUM_W'(1048575);
	localparam logic [1:0]        CHAN_B     = 2'd2;
	localparam logic [1:0]        CHAN_MAX   = 2'd2;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
		logic [DVD_W-1:0] dividend;  // left aligned
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DSR_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ design/clock_synth_divider_calc_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Divider settings calculator for a fractional-N clock synthesizer.
// Input stream (s_*): one item per request; s_tuser[1:0] = output channel,
// s_tdata[31:0] = target frequency in Hz. Result stream (m_*): one item per
// request; m_tuser[0] = status (1 = bad channel or frequency, all other
// fields zero), m_tuser[1] = PLL B select; m_tdata carries multiplier,
// numerator, denominator (fixed 1048575), multisynth divider and R code.
// Config channel (cfg_*): crystal frequency in Hz, always ready; write it
// only while no request is in flight. Reset value is 25 MHz.
// A good request uses one shared restoring divider (one quotient bit per
// cycle) that runs three or four divisions of 30, 30, 39 and 49 bits, after
// the R scaling step. A zero crystal skips the last two divisions. A bad
// request goes from idle straight to the final state. One item at a time:
// s_tready is high only while idle, so the next request is taken only
// after the result goes valid. The result sits in an output register;
// the next request is taken while it waits. If the receiver stalls, the
// finished settings wait in the final state until the register frees up.
// Async reset drops m_tvalid, returns to idle and restores the crystal.
module clock_synth_divider_calc_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] target_hz
	input  wire  [1:0]  s_tuser,   // [1:0] channel
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,   // [17:0] pll_mult, [37:18] pll_num,
	                               // [57:38] pll_denom, [68:58] ms_div,
	                               // [71:69] r_div_code
	output logic [1:0]  m_tuser,   // [0] status, [1] pll_b_select
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [26:0] cfg_data   // crystal_freq
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCALE, ST_DIV1, ST_WAIT1, ST_MUL1, ST_CHK, ST_DIV2,
		ST_WAIT2, ST_MUL2, ST_DIV3, ST_WAIT3, ST_DIV4, ST_WAIT4, ST_OUT
	} state_t;

	state_t                          state_q;
	logic [csdc_pkg::XTAL_W-1:0]     xtal_q;
	logic                            bad_q;
	logic                            pllb_q;
	logic [csdc_pkg::FREQ_W-1:0]     f_q;
	logic [csdc_pkg::CODE_W-1:0]     code_q;
	logic [csdc_pkg::DIVN_W-1:0]     msdiv_q;
	logic [csdc_pkg::FPLL_W-1:0]     fpll_q;
	logic [csdc_pkg::MULT_W-1:0]     mult_q;
	logic [csdc_pkg::NUM_W-1:0]      num_q;
	logic [csdc_pkg::XTAL_W-1:0]     xrem_q;

	logic                            in_bad;
	logic [csdc_pkg::FPLL_W-1:0]     prod;
	logic [csdc_pkg::DVD_W-1:0]      num_dvd;
	csdc_pkg::div_req_t              dreq;
	csdc_pkg::div_rsp_t              drsp;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);

	assign in_bad = (s_tuser > csdc_pkg::CHAN_MAX) || (s_tdata < csdc_pkg::HZ_MIN)
		|| (s_tdata > csdc_pkg::HZ_MAX);

	// the one multiplier: f * div, registered into fpll_q
	assign prod = csdc_pkg::FPLL_W'(f_q) * csdc_pkg::FPLL_W'(msdiv_q);

	// rem * 2 * 1048575 + xtal, rounding numerator for the last division
	assign num_dvd = csdc_pkg::DVD_W'({xrem_q, 21'b0})
		- csdc_pkg::DVD_W'({xrem_q, 1'b0}) + csdc_pkg::DVD_W'(xtal_q);

	always_comb begin
		dreq.start    = 1'b0;
		dreq.nbits    = csdc_pkg::CNT_W'(csdc_pkg::SHORT_W);
		dreq.dividend = {csdc_pkg::VCO_NOM, (csdc_pkg::DVD_W - csdc_pkg::SHORT_W)'(0)};
		dreq.divisor  = f_q;
		unique case (state_q)
			ST_DIV1: begin
				dreq.start = 1'b1;
			end
			ST_DIV2: begin
				// ceil(600 MHz / f)
				dreq.start    = 1'b1;
				dreq.dividend = {csdc_pkg::VCO_MIN + csdc_pkg::SHORT_W'(f_q) - 1'b1,
					(csdc_pkg::DVD_W - csdc_pkg::SHORT_W)'(0)};
			end
			ST_DIV3: begin
				// full VCO width: f * 900 can reach 135 GHz
				dreq.start    = (xtal_q != '0);
				dreq.nbits    = csdc_pkg::CNT_W'(csdc_pkg::FPLL_W);
				dreq.dividend = {fpll_q, (csdc_pkg::DVD_W - csdc_pkg::FPLL_W)'(0)};
				dreq.divisor  = csdc_pkg::DSR_W'(xtal_q);
			end
			ST_DIV4: begin
				dreq.start    = 1'b1;
				dreq.nbits    = csdc_pkg::CNT_W'(csdc_pkg::DVD_W);
				dreq.dividend = num_dvd;
				dreq.divisor  = {xtal_q, 1'b0};
			end
			default: begin
			end
		endcase
	end

	csdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_q <= csdc_pkg::XTAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			xtal_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= in_bad ? ST_OUT : ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (!(f_q < csdc_pkg::F_LOW && code_q != csdc_pkg::CODE_MAX)) begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1:  state_q <= ST_WAIT1;
				ST_WAIT1: if (drsp.done) state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_CHK;
				ST_CHK: begin
					if (fpll_q < csdc_pkg::VCO_MIN_W) begin
						state_q <= ST_DIV2;
					end else if (fpll_q > csdc_pkg::VCO_MAX_W) begin
						state_q <= ST_MUL2;
					end else begin
						state_q <= ST_DIV3;
					end
				end
				ST_DIV2:  state_q <= ST_WAIT2;
				ST_WAIT2: if (drsp.done) state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_DIV3;
				ST_DIV3:  state_q <= (xtal_q == '0) ? ST_OUT : ST_WAIT3;
				ST_WAIT3: if (drsp.done) state_q <= ST_DIV4;
				ST_DIV4:  state_q <= ST_WAIT4;
				ST_WAIT4: if (drsp.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					bad_q  <= in_bad;
					pllb_q <= (s_tuser == csdc_pkg::CHAN_B);
					f_q    <= s_tdata[csdc_pkg::FREQ_W-1:0];
					code_q <= '0;
				end
			end
			ST_SCALE: begin
				if (f_q < csdc_pkg::F_LOW && code_q != csdc_pkg::CODE_MAX) begin
					f_q    <= {f_q[csdc_pkg::FREQ_W-2:0], 1'b0};
					code_q <= code_q + 1'b1;
				end
			end
			ST_WAIT1: begin
				// clamp to 8..900
				if (drsp.quot[csdc_pkg::DVD_W-1:csdc_pkg::DIVN_W] != '0
					|| drsp.quot[csdc_pkg::DIVN_W-1:0] > csdc_pkg::MS_MAX) begin
					msdiv_q <= csdc_pkg::MS_MAX;
				end else if (drsp.quot[csdc_pkg::DIVN_W-1:0] < csdc_pkg::MS_MIN) begin
					msdiv_q <= csdc_pkg::MS_MIN;
				end else begin
					msdiv_q <= drsp.quot[csdc_pkg::DIVN_W-1:0];
				end
			end
			ST_MUL1, ST_MUL2: fpll_q <= prod;
			ST_CHK: begin
				if (!(fpll_q < csdc_pkg::VCO_MIN_W) && fpll_q > csdc_pkg::VCO_MAX_W) begin
					msdiv_q <= csdc_pkg::MS_MAX;
				end
			end
			ST_WAIT2: msdiv_q <= drsp.quot[csdc_pkg::DIVN_W-1:0];
			ST_DIV3: begin
				if (xtal_q == '0) begin
					mult_q <= csdc_pkg::MULT_MAX;
					num_q  <= '0;
				end
			end
			ST_WAIT3: begin
				if (drsp.quot[csdc_pkg::DVD_W-1:csdc_pkg::MULT_W] != '0) begin
					mult_q <= csdc_pkg::MULT_MAX;
				end else begin
					mult_q <= drsp.quot[csdc_pkg::MULT_W-1:0];
				end
				xrem_q <= drsp.rem[csdc_pkg::XTAL_W-1:0];
			end
			ST_WAIT4: num_q <= drsp.quot[csdc_pkg::NUM_W-1:0];
			ST_OUT: begin
				if (!m_tvalid || m_tready) begin
					if (bad_q) begin
						m_tuser <= 2'b01;
						m_tdata <= '0;
					end else begin
						m_tuser <= {pllb_q, 1'b0};
						m_tdata <= {code_q, msdiv_q, csdc_pkg::DENOM, num_q, mult_q};
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/csdc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module csdc_div (
	input  wire                clk,
	input  wire                arst_n,
	input  csdc_pkg::div_req_t req,
	output csdc_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [csdc_pkg::CNT_W-1:0]     cnt_q;
	logic [csdc_pkg::DVD_W-1:0]     dvd_q;
	logic [csdc_pkg::DVD_W-1:0]     quot_q;
	logic [csdc_pkg::DSR_W-1:0]     rem_q;
	logic [csdc_pkg::DSR_W-1:0]     dsr_q;
	logic [csdc_pkg::DSR_W:0]       trial;
	logic [csdc_pkg::DSR_W:0]       diff;

	assign trial = {rem_q, dvd_q[csdc_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == csdc_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			dsr_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[csdc_pkg::DVD_W-2:0], 1'b0};
			if (!diff[csdc_pkg::DSR_W]) begin
				rem_q  <= diff[csdc_pkg::DSR_W-1:0];
				quot_q <= {quot_q[csdc_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[csdc_pkg::DSR_W-1:0];
				quot_q <= {quot_q[csdc_pkg::DVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

@@ design/csdc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csdc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [71:0] m_tdata,
	input wire [1:0]  m_tuser
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("took a second request while busy");

	// rejected request: everything else zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 72'd0 && !m_tuser[1])
		else $error("rejected result carries data");

	// good result: fixed denominator, divider in range
	a_good_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[57:38] == 20'd1048575
			&& m_tdata[68:58] >= 11'd8 && m_tdata[68:58] <= 11'd1200)
		else $error("bad denominator or divider");

endmodule

bind clock_synth_divider_calc_unit csdc_checker u_csdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
